>>> hw/rtl/sfrp_pkg.sv
// ---------------------------------------------------------------------------
// sfrp_pkg
// Shared types, opcodes and flash command bytes for the record/play sequencer.
// ---------------------------------------------------------------------------
package sfrp_pkg;

    localparam int PAGE_BYTES_DEF   = 256;
    localparam int ADDRESS_BITS_DEF = 24;
    localparam int ADDR_MAX_W       = 24;
    localparam int CMD_DEPTH        = 4;
    localparam int STEP_W           = 3;

    // input operations
    localparam logic [2:0] OP_REC_START  = 3'd0;
    localparam logic [2:0] OP_STATUS     = 3'd1;
    localparam logic [2:0] OP_SAMPLE     = 3'd2;
    localparam logic [2:0] OP_STOP       = 3'd3;
    localparam logic [2:0] OP_PLAY_START = 3'd4;
    localparam logic [2:0] OP_READ_REPLY = 3'd5;

    // flash command bytes
    localparam logic [7:0] FL_WREN    = 8'h06;
    localparam logic [7:0] FL_RDSR    = 8'h05;
    localparam logic [7:0] FL_ERASE   = 8'hC7;
    localparam logic [7:0] FL_PROGRAM = 8'h02;
    localparam logic [7:0] FL_READ    = 8'h03;
    localparam logic [7:0] FL_DUMMY   = 8'hFF;
    localparam logic [7:0] FL_ZERO    = 8'h00;

    // returned byte kinds
    localparam logic [1:0] RK_NONE   = 2'd0;
    localparam logic [1:0] RK_STATUS = 2'd1;
    localparam logic [1:0] RK_DATA   = 2'd2;

    typedef enum logic [3:0] {
        SEQ_WEL         = 4'd0,
        SEQ_POLL        = 4'd1,
        SEQ_ERASE       = 4'd2,
        SEQ_RELEASE     = 4'd3,
        SEQ_PROG        = 4'd4,
        SEQ_SAMPLE      = 4'd5,
        SEQ_SAMPLE_LAST = 4'd6,
        SEQ_PLAY        = 4'd7,
        SEQ_READ        = 4'd8
    } t_seq;

    typedef struct packed {
        t_seq                  seq;
        logic [ADDR_MAX_W-1:0] addr;
        logic [7:0]            data;
        logic                  erase;
        logic                  record;
    } t_cmd;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       has_byte;
        logic       frame_start;
        logic       frame_end;
        logic [1:0] reply_kind;
        logic [6:0] pwm_duty;
        logic       pwm_update;
        logic       erase_active;
        logic       record_active;
        logic       last;
    } t_result;

    function automatic logic [STEP_W-1:0] seq_len(input t_seq seq);
        logic [STEP_W-1:0] len;
        unique case (seq)
            SEQ_WEL:         len = 3'd3;
            SEQ_POLL:        len = 3'd2;
            SEQ_ERASE:       len = 3'd3;
            SEQ_RELEASE:     len = 3'd1;
            SEQ_PROG:        len = 3'd4;
            SEQ_SAMPLE:      len = 3'd1;
            SEQ_SAMPLE_LAST: len = 3'd3;
            SEQ_PLAY:        len = 3'd5;
            SEQ_READ:        len = 3'd1;
            default:         len = 3'd1;
        endcase
        return len;
    endfunction

endpackage

>>> hw/rtl/sfrp_front.sv
// ---------------------------------------------------------------------------
// sfrp_front
// Tracks the record/play phase; each item gives at most one command sequence.
// ---------------------------------------------------------------------------
module sfrp_front #(
    parameter int PAGE_BYTES   = sfrp_pkg::PAGE_BYTES_DEF,
    parameter int ADDRESS_BITS = sfrp_pkg::ADDRESS_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [2:0]     i_operation,
    input  logic [7:0]     i_sample,
    input  logic [7:0]     i_reply_byte,
    output logic           o_cmd_valid,
    output sfrp_pkg::t_cmd o_cmd
);

    localparam int CNT_W = $clog2(PAGE_BYTES);

    typedef enum logic [6:0] {
        PH_IDLE       = 7'b0000001,
        PH_ERASE_WEL  = 7'b0000010,
        PH_ERASE_POLL = 7'b0000100,
        PH_PAGE_WEL   = 7'b0001000,
        PH_PAGE_DATA  = 7'b0010000,
        PH_PAGE_POLL  = 7'b0100000,
        PH_PLAY       = 7'b1000000
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [ADDRESS_BITS-1:0] r_page_addr, n_page_addr;
    logic [CNT_W-1:0]        r_byte_cnt, n_byte_cnt;
    logic                    r_stop, n_stop;
    logic                    busy;
    logic                    gen;
    sfrp_pkg::t_seq          seq;

    assign busy = i_reply_byte[0];

    always_comb begin
        n_phase     = r_phase;
        n_page_addr = r_page_addr;
        n_byte_cnt  = r_byte_cnt;
        n_stop      = r_stop;
        gen         = 1'b0;
        seq         = sfrp_pkg::SEQ_POLL;
        unique case (i_operation)
            sfrp_pkg::OP_REC_START: begin
                if (r_phase == PH_IDLE) begin
                    n_stop      = 1'b0;
                    n_byte_cnt  = '0;
                    n_page_addr = '0;
                    n_phase     = PH_ERASE_WEL;
                    gen         = 1'b1;
                    seq         = sfrp_pkg::SEQ_WEL;
                end
            end
            sfrp_pkg::OP_STATUS: begin
                priority if (r_phase == PH_ERASE_WEL) begin
                    gen = 1'b1;
                    if (!busy) begin
                        seq     = sfrp_pkg::SEQ_ERASE;
                        n_phase = PH_ERASE_POLL;
                    end
                end else if (r_phase == PH_ERASE_POLL || r_phase == PH_PAGE_POLL) begin
                    gen = 1'b1;
                    priority if (busy) begin
                        seq = sfrp_pkg::SEQ_POLL;
                    end else if (r_stop) begin
                        seq        = sfrp_pkg::SEQ_RELEASE;
                        n_phase    = PH_IDLE;
                        n_stop     = 1'b0;
                        n_byte_cnt = '0;
                    end else begin
                        seq     = sfrp_pkg::SEQ_WEL;
                        n_phase = PH_PAGE_WEL;
                    end
                end else if (r_phase == PH_PAGE_WEL) begin
                    gen = 1'b1;
                    if (!busy) begin
                        seq        = sfrp_pkg::SEQ_PROG;
                        n_byte_cnt = '0;
                        n_phase    = PH_PAGE_DATA;
                    end
                end else begin
                    gen = 1'b0;
                end
            end
            sfrp_pkg::OP_SAMPLE: begin
                if (r_phase == PH_PAGE_DATA) begin
                    gen = 1'b1;
                    if (r_byte_cnt == CNT_W'(PAGE_BYTES - 1)) begin
                        seq         = sfrp_pkg::SEQ_SAMPLE_LAST;
                        n_byte_cnt  = '0;
                        n_page_addr = r_page_addr + ADDRESS_BITS'(PAGE_BYTES);
                        n_phase     = PH_PAGE_POLL;
                    end else begin
                        seq        = sfrp_pkg::SEQ_SAMPLE;
                        n_byte_cnt = r_byte_cnt + 1'b1;
                    end
                end
            end
            sfrp_pkg::OP_STOP: begin
                priority if (r_phase == PH_PLAY) begin
                    gen     = 1'b1;
                    seq     = sfrp_pkg::SEQ_RELEASE;
                    n_phase = PH_IDLE;
                end else if (r_phase != PH_IDLE) begin
                    n_stop = 1'b1;
                end else begin
                    gen = 1'b0;
                end
            end
            sfrp_pkg::OP_PLAY_START: begin
                if (r_phase == PH_IDLE) begin
                    gen     = 1'b1;
                    seq     = sfrp_pkg::SEQ_PLAY;
                    n_phase = PH_PLAY;
                end
            end
            sfrp_pkg::OP_READ_REPLY: begin
                if (r_phase == PH_PLAY) begin
                    gen = 1'b1;
                    seq = sfrp_pkg::SEQ_READ;
                end
            end
            default: begin
                gen = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_cmd_valid  = i_accept && gen;
        o_cmd.seq    = seq;
        o_cmd.addr   = sfrp_pkg::ADDR_MAX_W'(r_page_addr);
        o_cmd.data   = (i_operation == sfrp_pkg::OP_READ_REPLY) ? i_reply_byte : i_sample;
        o_cmd.erase  = (n_phase == PH_ERASE_WEL) || (n_phase == PH_ERASE_POLL);
        o_cmd.record = (n_phase == PH_PAGE_WEL) || (n_phase == PH_PAGE_DATA)
                    || (n_phase == PH_PAGE_POLL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_page_addr <= '0;
            r_byte_cnt  <= '0;
            r_stop      <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_page_addr <= n_page_addr;
            r_byte_cnt  <= n_byte_cnt;
            r_stop      <= n_stop;
        end
    end

endmodule

>>> hw/rtl/sfrp_cmd_queue.sv
// ---------------------------------------------------------------------------
// sfrp_cmd_queue
// Short command queue between the front and the back end.
// ---------------------------------------------------------------------------
module sfrp_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  sfrp_pkg::t_cmd i_wr_cmd,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_valid,
    output sfrp_pkg::t_cmd o_cmd
);

    localparam int DEPTH = sfrp_pkg::CMD_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfrp_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("command queue count above depth");

    a_no_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> o_valid)
        else $error("back end popped an empty command queue");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> (r_count == $past(r_count) + 1'b1))
        else $error("command queue count lost a write");
`endif

endmodule

>>> hw/rtl/sfrp_back.sv
// ---------------------------------------------------------------------------
// sfrp_back
// Expands queued commands into SPI byte results, one per cycle unless stalled.
// ---------------------------------------------------------------------------
module sfrp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  sfrp_pkg::t_cmd    i_cmd,
    output logic              o_cmd_rd,
    input  logic              i_pop,
    output logic              o_out_valid,
    output sfrp_pkg::t_result o_out
);

    localparam int SW = sfrp_pkg::STEP_W;

    logic [SW-1:0]     r_step;
    logic              r_out_valid;
    sfrp_pkg::t_result r_out;
    sfrp_pkg::t_result res;
    logic              advance;
    logic              step_last;
    logic              poll_ff;

    assign advance   = i_cmd_valid && (!r_out_valid || i_pop);
    assign step_last = (r_step == sfrp_pkg::seq_len(i_cmd.seq) - 1'b1);
    assign o_cmd_rd  = advance && step_last;

    // second byte of a status poll sits at the last step of every sequence that polls
    assign poll_ff = step_last;

    always_comb begin
        res               = '0;
        res.erase_active  = i_cmd.erase;
        res.record_active = i_cmd.record;
        res.last          = step_last;
        unique case (i_cmd.seq)
            sfrp_pkg::SEQ_WEL, sfrp_pkg::SEQ_ERASE, sfrp_pkg::SEQ_SAMPLE_LAST,
            sfrp_pkg::SEQ_POLL: begin
                res.has_byte = 1'b1;
                priority if (r_step == '0 && i_cmd.seq != sfrp_pkg::SEQ_POLL) begin
                    res.frame_end = 1'b1;
                    if (i_cmd.seq == sfrp_pkg::SEQ_WEL) begin
                        res.tx_byte     = sfrp_pkg::FL_WREN;
                        res.frame_start = 1'b1;
                    end else if (i_cmd.seq == sfrp_pkg::SEQ_ERASE) begin
                        res.tx_byte     = sfrp_pkg::FL_ERASE;
                        res.frame_start = 1'b1;
                    end else begin
                        res.tx_byte    = i_cmd.data;
                        res.pwm_duty   = i_cmd.data[7:1];
                        res.pwm_update = 1'b1;
                    end
                end else if (poll_ff) begin
                    res.tx_byte    = sfrp_pkg::FL_DUMMY;
                    res.frame_end  = 1'b1;
                    res.reply_kind = sfrp_pkg::RK_STATUS;
                end else begin
                    res.tx_byte     = sfrp_pkg::FL_RDSR;
                    res.frame_start = 1'b1;
                end
            end
            sfrp_pkg::SEQ_RELEASE: begin
                res.frame_end = 1'b1;
            end
            sfrp_pkg::SEQ_PROG: begin
                res.has_byte = 1'b1;
                unique case (r_step)
                    3'd0: begin
                        res.tx_byte     = sfrp_pkg::FL_PROGRAM;
                        res.frame_start = 1'b1;
                    end
                    3'd1:    res.tx_byte = i_cmd.addr[23:16];
                    3'd2:    res.tx_byte = i_cmd.addr[15:8];
                    default: res.tx_byte = i_cmd.addr[7:0];
                endcase
            end
            sfrp_pkg::SEQ_SAMPLE: begin
                res.has_byte   = 1'b1;
                res.tx_byte    = i_cmd.data;
                res.pwm_duty   = i_cmd.data[7:1];
                res.pwm_update = 1'b1;
            end
            sfrp_pkg::SEQ_PLAY: begin
                res.has_byte = 1'b1;
                priority if (r_step == '0) begin
                    res.tx_byte     = sfrp_pkg::FL_READ;
                    res.frame_start = 1'b1;
                end else if (step_last) begin
                    res.tx_byte    = sfrp_pkg::FL_DUMMY;
                    res.reply_kind = sfrp_pkg::RK_DATA;
                end else begin
                    res.tx_byte = sfrp_pkg::FL_ZERO;
                end
            end
            sfrp_pkg::SEQ_READ: begin
                res.has_byte   = 1'b1;
                res.tx_byte    = sfrp_pkg::FL_DUMMY;
                res.reply_kind = sfrp_pkg::RK_DATA;
                res.pwm_duty   = i_cmd.data[7:1];
                res.pwm_update = 1'b1;
            end
            default: begin
                res.frame_end = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_step <= step_last ? '0 : r_step + 1'b1;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> hw/rtl/serial_flash_record_play_sequencer.sv
// ---------------------------------------------------------------------------
// serial_flash_record_play_sequencer
// SPI NOR flash record/play command sequencer: front phase tracker, command
// queue, and a back end that streams the SPI byte results.
// ---------------------------------------------------------------------------
// each item's command is queued, then its results are registered
// throughput: one result per cycle from the back end while the receiver pops;
//   an item yields 0 to 5 results, set by the back end's byte sequencer
// input is taken every cycle while the four-entry command queue has room
// reset (sync, active low): idle phase, address and counters zero, queues empty
module serial_flash_record_play_sequencer #(
    parameter int PAGE_BYTES   = sfrp_pkg::PAGE_BYTES_DEF,
    parameter int ADDRESS_BITS = sfrp_pkg::ADDRESS_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] i_operation,
    input  logic [7:0] i_sample,
    input  logic [7:0] i_reply_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_tx_byte,
    output logic       o_has_byte,
    output logic       o_frame_start,
    output logic       o_frame_end,
    output logic [1:0] o_reply_kind,
    output logic [6:0] o_pwm_duty,
    output logic       o_pwm_update,
    output logic       o_erase_active,
    output logic       o_record_active,
    output logic       o_last
);

    logic              accept;
    logic              fe_cmd_valid;
    sfrp_pkg::t_cmd    fe_cmd;
    logic              q_valid;
    sfrp_pkg::t_cmd    q_cmd;
    logic              q_rd;
    logic              out_valid;
    sfrp_pkg::t_result out;

    assign accept = push && !full;

    sfrp_front #(
        .PAGE_BYTES   (PAGE_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_operation  (i_operation),
        .i_sample     (i_sample),
        .i_reply_byte (i_reply_byte),
        .o_cmd_valid  (fe_cmd_valid),
        .o_cmd        (fe_cmd)
    );

    sfrp_cmd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (fe_cmd_valid),
        .i_wr_cmd (fe_cmd),
        .o_full   (full),
        .i_rd     (q_rd),
        .o_valid  (q_valid),
        .o_cmd    (q_cmd)
    );

    sfrp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_rd    (q_rd),
        .i_pop       (pop),
        .o_out_valid (out_valid),
        .o_out       (out)
    );

    assign empty           = !out_valid;
    assign o_tx_byte       = out.tx_byte;
    assign o_has_byte      = out.has_byte;
    assign o_frame_start   = out.frame_start;
    assign o_frame_end     = out.frame_end;
    assign o_reply_kind    = out.reply_kind;
    assign o_pwm_duty      = out.pwm_duty;
    assign o_pwm_update    = out.pwm_update;
    assign o_erase_active  = out.erase_active;
    assign o_record_active = out.record_active;
    assign o_last          = out.last;

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the serial flash record/play sequencer. Directed
// items walk the record, erase, page program and play sequences and their
// corner cases, then fill a whole page with random audio, cross the page
// boundary and open the next page. A scoreboard predicts every SPI byte
// result and checks each popped result field by field. Random sender gaps
// and receiver stalls change in phases with the count of active items.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW = sfrp_pkg::ADDR_MAX_W;
    localparam logic [2:0] OP_SPARE = 3'd6;
    localparam logic [AW-1:0] ADDR_MASK =
        AW'((64'd1 << sfrp_pkg::ADDRESS_BITS_DEF) - 64'd1);
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int END_CYCLES = 16;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ERASE_WEL,
        PH_ERASE_POLL,
        PH_PAGE_WEL,
        PH_PAGE_DATA,
        PH_PAGE_POLL,
        PH_PLAY
    } t_phase;

    class flash_scoreboard;
        sfrp_pkg::t_result      expected[$];
        sfrp_pkg::t_result      batch[$];
        t_phase                 phase = PH_IDLE;
        logic [AW-1:0]          page_addr = '0;
        int                     byte_cnt = 0;
        bit                     stop_pend = 0;
        int                     errors = 0;

        function void emit(logic [7:0] tx, logic has, logic fs, logic fe,
                           logic [1:0] kind, logic [6:0] duty, logic upd);
            sfrp_pkg::t_result r;
            r = '0;
            r.tx_byte = tx;
            r.has_byte = has;
            r.frame_start = fs;
            r.frame_end = fe;
            r.reply_kind = kind;
            r.pwm_duty = duty;
            r.pwm_update = upd;
            batch.push_back(r);
        endfunction

        function void poll();
            emit(sfrp_pkg::FL_RDSR, 1'b1, 1'b1, 1'b0, sfrp_pkg::RK_NONE, 7'd0, 1'b0);
            emit(sfrp_pkg::FL_DUMMY, 1'b1, 1'b0, 1'b1, sfrp_pkg::RK_STATUS, 7'd0, 1'b0);
        endfunction

        function void write_enable();
            emit(sfrp_pkg::FL_WREN, 1'b1, 1'b1, 1'b1, sfrp_pkg::RK_NONE, 7'd0, 1'b0);
            poll();
        endfunction

        // predicts the results of one accepted item, returns how many
        function int note_input(logic [2:0] op, logic [7:0] smp, logic [7:0] rep);
            sfrp_pkg::t_result r;
            bit busy;
            busy = rep[0];
            batch.delete();
            case (op)
                sfrp_pkg::OP_REC_START: begin
                    if (phase == PH_IDLE) begin
                        stop_pend = 0;
                        byte_cnt = 0;
                        page_addr = '0;
                        phase = PH_ERASE_WEL;
                        write_enable();
                    end
                end
                sfrp_pkg::OP_STATUS: begin
                    if (phase == PH_ERASE_WEL) begin
                        if (busy) begin
                            poll();
                        end else begin
                            emit(sfrp_pkg::FL_ERASE, 1'b1, 1'b1, 1'b1,
                                 sfrp_pkg::RK_NONE, 7'd0, 1'b0);
                            poll();
                            phase = PH_ERASE_POLL;
                        end
                    end else if (phase == PH_ERASE_POLL || phase == PH_PAGE_POLL) begin
                        if (busy) begin
                            poll();
                        end else if (stop_pend) begin
                            phase = PH_IDLE;
                            stop_pend = 0;
                            byte_cnt = 0;
                            emit(sfrp_pkg::FL_ZERO, 1'b0, 1'b0, 1'b1,
                                 sfrp_pkg::RK_NONE, 7'd0, 1'b0);
                        end else begin
                            phase = PH_PAGE_WEL;
                            write_enable();
                        end
                    end else if (phase == PH_PAGE_WEL) begin
                        if (busy) begin
                            poll();
                        end else begin
                            emit(sfrp_pkg::FL_PROGRAM, 1'b1, 1'b1, 1'b0,
                                 sfrp_pkg::RK_NONE, 7'd0, 1'b0);
                            emit(page_addr[23:16], 1'b1, 1'b0, 1'b0,
                                 sfrp_pkg::RK_NONE, 7'd0, 1'b0);
                            emit(page_addr[15:8], 1'b1, 1'b0, 1'b0,
                                 sfrp_pkg::RK_NONE, 7'd0, 1'b0);
                            emit(page_addr[7:0], 1'b1, 1'b0, 1'b0,
                                 sfrp_pkg::RK_NONE, 7'd0, 1'b0);
                            byte_cnt = 0;
                            phase = PH_PAGE_DATA;
                        end
                    end
                end
                sfrp_pkg::OP_SAMPLE: begin
                    if (phase == PH_PAGE_DATA) begin
                        if (byte_cnt >= sfrp_pkg::PAGE_BYTES_DEF - 1) begin
                            emit(smp, 1'b1, 1'b0, 1'b1, sfrp_pkg::RK_NONE, smp[7:1], 1'b1);
                            poll();
                            byte_cnt = 0;
                            page_addr = AW'((page_addr + sfrp_pkg::PAGE_BYTES_DEF)
                                            & ADDR_MASK);
                            phase = PH_PAGE_POLL;
                        end else begin
                            emit(smp, 1'b1, 1'b0, 1'b0, sfrp_pkg::RK_NONE, smp[7:1], 1'b1);
                            byte_cnt++;
                        end
                    end
                end
                sfrp_pkg::OP_STOP: begin
                    if (phase == PH_PLAY) begin
                        emit(sfrp_pkg::FL_ZERO, 1'b0, 1'b0, 1'b1,
                             sfrp_pkg::RK_NONE, 7'd0, 1'b0);
                        phase = PH_IDLE;
                    end else if (phase != PH_IDLE) begin
                        stop_pend = 1;
                    end
                end
                sfrp_pkg::OP_PLAY_START: begin
                    if (phase == PH_IDLE) begin
                        emit(sfrp_pkg::FL_READ, 1'b1, 1'b1, 1'b0,
                             sfrp_pkg::RK_NONE, 7'd0, 1'b0);
                        repeat (3) emit(sfrp_pkg::FL_ZERO, 1'b1, 1'b0, 1'b0,
                                        sfrp_pkg::RK_NONE, 7'd0, 1'b0);
                        emit(sfrp_pkg::FL_DUMMY, 1'b1, 1'b0, 1'b0,
                             sfrp_pkg::RK_DATA, 7'd0, 1'b0);
                        phase = PH_PLAY;
                    end
                end
                sfrp_pkg::OP_READ_REPLY: begin
                    if (phase == PH_PLAY)
                        emit(sfrp_pkg::FL_DUMMY, 1'b1, 1'b0, 1'b0,
                             sfrp_pkg::RK_DATA, rep[7:1], 1'b1);
                end
                default: ;
            endcase
            foreach (batch[k]) begin
                r = batch[k];
                r.erase_active = (phase == PH_ERASE_WEL || phase == PH_ERASE_POLL);
                r.record_active = (phase == PH_PAGE_WEL || phase == PH_PAGE_DATA ||
                                   phase == PH_PAGE_POLL);
                r.last = (k == batch.size() - 1);
                expected.push_back(r);
            end
            return batch.size();
        endfunction

        function void compare(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(sfrp_pkg::t_result got);
            sfrp_pkg::t_result want;
            if (expected.size() == 0) begin
                $display("%0t: unexpected result expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = expected.pop_front();
            compare("tx_byte", want.tx_byte, got.tx_byte);
            compare("has_byte", want.has_byte, got.has_byte);
            compare("frame_start", want.frame_start, got.frame_start);
            compare("frame_end", want.frame_end, got.frame_end);
            compare("reply_kind", want.reply_kind, got.reply_kind);
            compare("pwm_duty", want.pwm_duty, got.pwm_duty);
            compare("pwm_update", want.pwm_update, got.pwm_update);
            compare("erase_active", want.erase_active, got.erase_active);
            compare("record_active", want.record_active, got.record_active);
            compare("last", want.last, got.last);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [2:0] i_operation = '0;
    logic [7:0] i_sample = '0;
    logic [7:0] i_reply_byte = '0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] o_tx_byte;
    logic       o_has_byte;
    logic       o_frame_start;
    logic       o_frame_end;
    logic [1:0] o_reply_kind;
    logic [6:0] o_pwm_duty;
    logic       o_pwm_update;
    logic       o_erase_active;
    logic       o_record_active;
    logic       o_last;

    flash_scoreboard board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int active_items = 0;
    int quiet_cycles = 0;

    serial_flash_record_play_sequencer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_operation     (i_operation),
        .i_sample        (i_sample),
        .i_reply_byte    (i_reply_byte),
        .empty           (empty),
        .pop             (pop),
        .o_tx_byte       (o_tx_byte),
        .o_has_byte      (o_has_byte),
        .o_frame_start   (o_frame_start),
        .o_frame_end     (o_frame_end),
        .o_reply_kind    (o_reply_kind),
        .o_pwm_duty      (o_pwm_duty),
        .o_pwm_update    (o_pwm_update),
        .o_erase_active  (o_erase_active),
        .o_record_active (o_record_active),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic send_item(logic [2:0] op, logic [7:0] smp, logic [7:0] rep);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        i_operation <= op;
        i_sample <= smp;
        i_reply_byte <= rep;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        if (board.note_input(op, smp, rep) > 0) active_items++;
        case ((active_items / 40) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
        endcase
    endtask

    task automatic drain_results();
        push <= 1'b0;
        do @(posedge i_clk); while (board.expected.size() != 0);
    endtask

    // result side
    initial begin
        forever begin
            @(posedge i_clk);
            if (pop && !empty)
                board.check_result({o_tx_byte, o_has_byte, o_frame_start, o_frame_end,
                                    o_reply_kind, o_pwm_duty, o_pwm_update,
                                    o_erase_active, o_record_active, o_last});
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ignored while idle
        send_item(sfrp_pkg::OP_STOP, 8'h00, 8'h00);
        send_item(sfrp_pkg::OP_STATUS, 8'h00, 8'h00);
        send_item(sfrp_pkg::OP_SAMPLE, 8'hFF, 8'h00);
        send_item(sfrp_pkg::OP_READ_REPLY, 8'h00, 8'hFF);
        send_item(OP_SPARE, 8'hFF, 8'hFF);
        // play session
        send_item(sfrp_pkg::OP_PLAY_START, 8'h00, 8'h00);
        send_item(sfrp_pkg::OP_PLAY_START, 8'h00, 8'h00);
        send_item(sfrp_pkg::OP_REC_START, 8'h00, 8'h00);
        send_item(sfrp_pkg::OP_READ_REPLY, 8'h00, 8'hFF);
        send_item(sfrp_pkg::OP_READ_REPLY, 8'hFF, 8'h00);
        send_item(sfrp_pkg::OP_STOP, 8'h00, 8'h00);
        // erase with busy polls, stop honored after erase
        send_item(sfrp_pkg::OP_REC_START, 8'h00, 8'h00);
        send_item(sfrp_pkg::OP_REC_START, 8'h00, 8'h00);
        send_item(sfrp_pkg::OP_STATUS, 8'h00, 8'h01);
        send_item(sfrp_pkg::OP_STATUS, 8'h00, 8'hFE);
        send_item(sfrp_pkg::OP_STATUS, 8'h00, 8'hFF);
        send_item(sfrp_pkg::OP_STOP, 8'h00, 8'h00);
        send_item(sfrp_pkg::OP_STATUS, 8'h00, 8'h00);
        // into the first page
        send_item(sfrp_pkg::OP_REC_START, 8'h00, 8'h00);
        send_item(sfrp_pkg::OP_STATUS, 8'h00, 8'h00);
        send_item(sfrp_pkg::OP_STATUS, 8'h00, 8'h00);
        send_item(sfrp_pkg::OP_STATUS, 8'h00, 8'h01);
        send_item(sfrp_pkg::OP_STATUS, 8'h00, 8'h00);
        send_item(sfrp_pkg::OP_SAMPLE, 8'h00, 8'hFF);
        send_item(sfrp_pkg::OP_SAMPLE, 8'hFF, 8'h00);

        drain_results();

        // rest of the first page with random audio
        for (int n = 2; n < sfrp_pkg::PAGE_BYTES_DEF; n++) begin
            send_item(sfrp_pkg::OP_SAMPLE, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        end
        // page poll, then program of the next page
        send_item(sfrp_pkg::OP_STATUS, 8'h00, 8'h01);
        send_item(sfrp_pkg::OP_STATUS, 8'h00, 8'h00);
        send_item(sfrp_pkg::OP_STATUS, 8'h00, 8'h03);
        send_item(sfrp_pkg::OP_STATUS, 8'h00, 8'h00);
        send_item(sfrp_pkg::OP_SAMPLE, 8'h80, 8'h00);
        send_item(sfrp_pkg::OP_STOP, 8'h00, 8'h00);
        send_item(sfrp_pkg::OP_SAMPLE, 8'h7F, 8'h00);

        recv_stall_pct = 0;
        drain_results();
        repeat (END_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.expected.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
